FILE: rtl/lrupr_pkg.sv
// Shared sizes, constants and cell interface structs for the LRU page replacement block.
// Used by lrupr_cell and lru_page_replacement; depends on nothing else.
`default_nettype none

package lrupr_pkg;

   localparam int MAX_FRAME_COUNT = 8;
   localparam int PAGE_BITS       = 16;
   localparam int FRAME_BITS      = (MAX_FRAME_COUNT > 1) ? $clog2(MAX_FRAME_COUNT) : 1;
   localparam int COUNT_BITS      = $clog2(MAX_FRAME_COUNT + 1);
   localparam int CSR_BITS        = 4;
   localparam int FAULT_BITS      = 32;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic [PAGE_BITS-1:0]  page;
      logic                  cmp_en;
      logic                  upd_en;
      logic [FRAME_BITS-1:0] upd_frame;
      logic [COUNT_BITS-1:0] upd_limit;
      logic                  wr_tag;
      logic [COUNT_BITS-1:0] filled;
      logic [COUNT_BITS-1:0] count;
   } cmd_type;

   // Running search results handed from one cell to the next.
   typedef struct packed {
      logic                  hit_found;
      logic [FRAME_BITS-1:0] hit_idx;
      logic [FRAME_BITS-1:0] hit_rank;
      logic [FRAME_BITS-1:0] vict_idx;
      logic [FRAME_BITS-1:0] vict_rank;
      logic [PAGE_BITS-1:0]  vict_tag;
   } chain_type;

endpackage

`default_nettype wire

FILE: rtl/lrupr_cell.sv
// One page frame of the LRU tracker: tag, recency rank and registered tag match.
// Depends on lrupr_pkg for sizes and the cmd_type / chain_type structs.
`default_nettype none

module lrupr_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lrupr_pkg::FRAME_BITS-1:0] cell_idx,
   input  wire lrupr_pkg::cmd_type            cmd,
   input  wire lrupr_pkg::chain_type          chain_in,
   output lrupr_pkg::chain_type               chain_out
);
   import lrupr_pkg::*;

   logic [PAGE_BITS-1:0]  tag_ff, tag_in;
   logic [FRAME_BITS-1:0] rank_ff, rank_in;
   logic                  match_ff, match_in;
   logic                  filled_cell;
   logic                  in_count;
   logic [COUNT_BITS-1:0] idx_ext;

   assign idx_ext     = COUNT_BITS'(cell_idx);
   assign filled_cell = (idx_ext < cmd.filled);
   assign in_count    = (idx_ext < cmd.count);

   // Pass the search along: first matching filled frame, oldest frame within the count.
   always_comb begin
      chain_out = chain_in;
      if (!chain_in.hit_found && match_ff && filled_cell) begin
         chain_out.hit_found = 1'b1;
         chain_out.hit_idx   = cell_idx;
         chain_out.hit_rank  = rank_ff;
      end
      if (in_count && (rank_ff > chain_in.vict_rank || cell_idx == '0)) begin
         chain_out.vict_idx  = cell_idx;
         chain_out.vict_rank = rank_ff;
         chain_out.vict_tag  = tag_ff;
      end
   end

   always_comb begin
      tag_in   = tag_ff;
      rank_in  = rank_ff;
      match_in = match_ff;
      if (cmd.cmp_en) begin
         match_in = (tag_ff == cmd.page);
      end
      if (cmd.upd_en) begin
         if (cmd.upd_frame == cell_idx) begin
            rank_in = '0;
            if (cmd.wr_tag) begin
               tag_in = cmd.page;
            end
         end else if (filled_cell && (COUNT_BITS'(rank_ff) < cmd.upd_limit)) begin
            // age frames younger than the touched one
            rank_in = rank_ff + FRAME_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
      end else begin
         rank_ff <= rank_in;
      end
      tag_ff   <= tag_in;
      match_ff <= match_in;
   end

endmodule

`default_nettype wire

FILE: rtl/lru_page_replacement.sv
// Top level of the fully associative LRU page replacement tracker: controller and cell row.
// Depends on lrupr_pkg and lrupr_cell.
//
//   channel   ports                          handshake
//   -------   -----------------------------  ------------------------------------
//   request   start, busy, req_page          item taken when start & !busy
//   response  rsp_valid, rsp_*               one-cycle strobe, no backpressure
//   csr       csr_valid, csr_ready, csr_wdata write when csr_valid & csr_ready
//
// For each item, the accept edge loads the page and registers the tag compare in
// every cell; the next edge runs the hit and victim search along the cell row,
// writes the tag on a miss, updates the ranks, and loads the response registers.
// busy is high for the one cycle between those edges; a new item may start the
// cycle after, while the response strobe is up.
// Reset clears ranks, filled count, fault count and sets the frame count to its maximum.
`default_nettype none

module lru_page_replacement (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [lrupr_pkg::PAGE_BITS-1:0]  req_page,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic [lrupr_pkg::FRAME_BITS-1:0]      rsp_frame,
   output logic                                  rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_BITS-1:0]       rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_BITS-1:0]      rsp_fault_total,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lrupr_pkg::CSR_BITS-1:0]   csr_wdata
);
   import lrupr_pkg::*;

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type             state_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] filled_ff;
   logic [FAULT_BITS-1:0] fault_ff;

   logic                  rsp_valid_ff, rsp_hit_ff, rsp_ev_valid_ff;
   logic [FRAME_BITS-1:0] rsp_frame_ff;
   logic [PAGE_BITS-1:0]  rsp_ev_page_ff;

   cmd_type               cmd;
   chain_type             chain [MAX_FRAME_COUNT+1];
   chain_type             chain_end;
   logic                  accept;
   logic                  exec;
   logic                  fill;
   logic                  evict;
   logic [FRAME_BITS-1:0] sel_frame;
   logic [FAULT_BITS-1:0] fault_in;

   assign accept    = start && (state_ff == ST_IDLE);
   assign exec      = (state_ff == ST_EXEC);
   assign chain[0]  = '0;
   assign chain_end = chain[MAX_FRAME_COUNT];

   genvar g;
   generate
      for (g = 0; g < MAX_FRAME_COUNT; g++) begin : g_cell
         lrupr_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cell_idx  (FRAME_BITS'(g)),
            .cmd       (cmd),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1])
         );
      end
   endgenerate

   always_comb begin
      fill  = !chain_end.hit_found && (filled_ff < count_ff);
      evict = !chain_end.hit_found && !fill;
      if (chain_end.hit_found) begin
         sel_frame = chain_end.hit_idx;
      end else if (fill) begin
         sel_frame = filled_ff[FRAME_BITS-1:0];
      end else begin
         sel_frame = chain_end.vict_idx;
      end

      cmd.page      = exec ? page_ff : req_page;
      cmd.cmp_en    = accept;
      cmd.upd_en    = exec;
      cmd.upd_frame = sel_frame;
      cmd.wr_tag    = !chain_end.hit_found;
      cmd.filled    = filled_ff;
      cmd.count     = count_ff;
      if (chain_end.hit_found) begin
         cmd.upd_limit = COUNT_BITS'(chain_end.hit_rank);
      end else if (fill) begin
         cmd.upd_limit = COUNT_BITS'(MAX_FRAME_COUNT);
      end else begin
         cmd.upd_limit = COUNT_BITS'(chain_end.vict_rank);
      end

      fault_in = fault_ff;
      if (!chain_end.hit_found && (fault_ff != '1)) begin
         fault_in = fault_ff + FAULT_BITS'(1);
      end

      // clamp the frame count into 1..MAX_FRAME_COUNT
      if (csr_wdata == '0) begin
         count_in = COUNT_BITS'(1);
      end else if (32'(csr_wdata) > 32'(MAX_FRAME_COUNT)) begin
         count_in = COUNT_BITS'(MAX_FRAME_COUNT);
      end else begin
         count_in = COUNT_BITS'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_BITS'(MAX_FRAME_COUNT);
         filled_ff    <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            count_ff <= count_in;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
               fault_ff     <= fault_in;
               if (fill) begin
                  filled_ff <= filled_ff + COUNT_BITS'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (accept) begin
         page_ff <= req_page;
      end
      if (exec) begin
         rsp_hit_ff      <= chain_end.hit_found;
         rsp_frame_ff    <= sel_frame;
         rsp_ev_valid_ff <= evict;
         rsp_ev_page_ff  <= evict ? chain_end.vict_tag : '0;
      end
   end

   assign busy              = exec;
   assign csr_ready         = !exec;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame         = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = fault_ff;

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid)
      else $error("execute cycle produced no response");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(exec))
      else $error("response strobe without an execute cycle");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted_valid)
      else $error("hit reported an eviction");

   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_fault_total != '0))
      else $error("fault with zero fault total");

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      32'(filled_ff) <= 32'(MAX_FRAME_COUNT))
      else $error("filled frame count out of range");

endmodule

`default_nettype wire
